### hdl/cst_pkg.sv
// Shared types and constants for the client session table.
// No dependencies; used by the cell, the top level and the testbench.
`default_nettype none
package cst_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam logic [4:0]  LIMIT_RST   = 5'd16;
  localparam logic [31:0] TIMEOUT_RST = 32'd10000;

  // register indexes (byte address / 4)
  localparam logic REG_CLIENT_LIMIT = 1'b0;
  localparam logic REG_TIMEOUT      = 1'b1;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_TICK   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_REFRESHED = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FOUND     = 3'd5,
    ST_TICK_DONE = 3'd6
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_BUSY = 1'b1
  } ctrl_state_e;

  // request travelling down the cell row
  typedef struct packed {
    logic        live;
    action_e     action;
    logic [31:0] ip_addr;
    logic [15:0] port_num;
    logic [31:0] now_ms;
    logic        hit;
    logic        free_ok;
  } tok_t;

  // new-entry write broadcast to all cells
  typedef struct packed {
    logic        en;
    logic [31:0] ip_addr;
    logic [15:0] port_num;
    logic [31:0] now_ms;
  } alloc_t;

endpackage
`default_nettype wire

### hdl/cst_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on nothing; payload widths are fixed by the field list.
`default_nettype none
interface cst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] ip_addr;
  logic [15:0] port_num;
  logic [31:0] now_ms;

  modport source (output valid, action, ip_addr, port_num, now_ms, input ready);
  modport sink   (input valid, action, ip_addr, port_num, now_ms, output ready);
endinterface

interface cst_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic [4:0]  live_count;
  logic [4:0]  pruned_count;

  modport source (output valid, status, slot, live_count, pruned_count, input ready);
  modport sink   (input valid, status, slot, live_count, pruned_count, output ready);
endinterface
`default_nettype wire

### hdl/cst_cell.sv
// One table entry: key, timestamp and valid bit, plus one hop of the request row.
// Depends on cst_pkg (tok_t, alloc_t, action_e).
`default_nettype none
module cst_cell #(
  parameter int TABLE_DEPTH = cst_pkg::TABLE_DEPTH_DEF,
  parameter int CELL_IDX    = 0,
  localparam int SLOT_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  [31:0]         timeout_i,
  input  cst_pkg::alloc_t     alloc_i,
  input  wire  [SLOT_W-1:0]   alloc_slot_i,
  input  cst_pkg::tok_t       tok_i,
  input  wire  [SLOT_W-1:0]   hit_slot_i,
  input  wire  [SLOT_W-1:0]   free_slot_i,
  input  wire  [CNT_W-1:0]    pruned_i,
  output cst_pkg::tok_t       tok_o,
  output logic [SLOT_W-1:0]   hit_slot_o,
  output logic [SLOT_W-1:0]   free_slot_o,
  output logic [CNT_W-1:0]    pruned_o
);

  localparam logic [SLOT_W-1:0] IDX = SLOT_W'(CELL_IDX);

  logic               valid_q, valid_d;
  logic [31:0]        ip_q, ip_d;
  logic [15:0]        port_q, port_d;
  logic [31:0]        seen_q, seen_d;
  cst_pkg::tok_t      tok_q, tok_d;
  logic [SLOT_W-1:0]  hit_slot_q, hit_slot_d;
  logic [SLOT_W-1:0]  free_slot_q, free_slot_d;
  logic [CNT_W-1:0]   pruned_q, pruned_d;

  logic        match;
  logic        first;
  logic [31:0] idle_time;
  logic        expired;

  always_comb begin
    match     = valid_q && (ip_q == tok_i.ip_addr) && (port_q == tok_i.port_num);
    first     = match && !tok_i.hit;
    idle_time = tok_i.now_ms - seen_q;  // wraps mod 2^32
    expired   = valid_q && (idle_time > timeout_i);

    valid_d     = valid_q;
    ip_d        = ip_q;
    port_d      = port_q;
    seen_d      = seen_q;
    tok_d       = tok_i;
    hit_slot_d  = hit_slot_i;
    free_slot_d = free_slot_i;
    pruned_d    = pruned_i;

    if (tok_i.live) begin
      case (tok_i.action)
        cst_pkg::ACT_ADD: begin
          if (first) seen_d = tok_i.now_ms;
        end
        cst_pkg::ACT_REMOVE: begin
          if (first) valid_d = 1'b0;
        end
        cst_pkg::ACT_TICK: begin
          if (expired) begin
            valid_d  = 1'b0;
            pruned_d = pruned_i + CNT_W'(1);
          end
        end
        default: ;
      endcase
      if (tok_i.action != cst_pkg::ACT_TICK) begin
        tok_d.hit = tok_i.hit | match;
        if (first) hit_slot_d = IDX;
      end
      // lowest free slot wins
      if (!valid_q && !tok_i.free_ok) begin
        tok_d.free_ok = 1'b1;
        free_slot_d   = IDX;
      end
    end

    // new entry is written after the sweep, never while a request is here
    if (alloc_i.en && (alloc_slot_i == IDX)) begin
      valid_d = 1'b1;
      ip_d    = alloc_i.ip_addr;
      port_d  = alloc_i.port_num;
      seen_d  = alloc_i.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ip_q           <= ip_d;
    port_q         <= port_d;
    seen_q         <= seen_d;
    hit_slot_q     <= hit_slot_d;
    free_slot_q    <= free_slot_d;
    pruned_q       <= pruned_d;
  end

  assign tok_o       = tok_q;
  assign hit_slot_o  = hit_slot_q;
  assign free_slot_o = free_slot_q;
  assign pruned_o    = pruned_q;

endmodule
`default_nettype wire

### hdl/client_session_table_with_aging.sv
// Top level: APB config registers, request launch, cell row and result staging.
// Depends on cst_pkg, cst_req_if / cst_rsp_if and cst_cell.
//
//   channel   dir  handshake        payload
//   req_i     in   valid/ready      action, ip_addr, port_num, now_ms
//   rsp_o     out  valid/ready      status, slot, live_count, pruned_count
//   apb       in   psel/penable     paddr (reg*4), pwdata, prdata; pready tied high
//
// Each request walks the row of TABLE_DEPTH cells, one cell per cycle; a new
// entry is written after the walk. The result passes from the last cell to the
// hold register and then the output register; the next request is taken once
// the walk is done and the hold register is empty, one item in flight at a time.
// The result sits in a hold register, then the output register, so a stalled
// response does not block the next request until the hold register is also full.
// Reset clears valid bits, live count and config; no clearing pass is needed.
`default_nettype none
module client_session_table_with_aging #(
  parameter int TABLE_DEPTH = cst_pkg::TABLE_DEPTH_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  cst_req_if.sink      req_i,
  cst_rsp_if.source    rsp_o,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

  // ---------------- config registers
  logic [4:0]  limit_q;
  logic [31:0] timeout_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= cst_pkg::LIMIT_RST;
      timeout_q <= cst_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == cst_pkg::REG_CLIENT_LIMIT) limit_q <= pwdata[4:0];
      else                                       timeout_q <= pwdata;
    end
  end

  always_comb begin
    if (paddr[2] == cst_pkg::REG_TIMEOUT) prdata = timeout_q;
    else                                  prdata = {27'b0, limit_q};
  end

  // ---------------- control
  cst_pkg::ctrl_state_e state_q, state_d;
  logic                 in_accept;
  logic                 hold_valid_q, hold_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic                 end_live;

  cst_pkg::tok_t        tok    [0:TABLE_DEPTH];
  logic [SLOT_W-1:0]    hslot  [0:TABLE_DEPTH];
  logic [SLOT_W-1:0]    fslot  [0:TABLE_DEPTH];
  logic [CNT_W-1:0]     pruned [0:TABLE_DEPTH];

  cst_pkg::tok_t        launch_q, launch_d;
  cst_pkg::alloc_t      alloc;
  logic [CNT_W-1:0]     total_q, total_d;

  assign req_i.ready = (state_q == cst_pkg::S_IDLE) && !hold_valid_q;
  assign in_accept   = req_i.valid && req_i.ready;
  assign end_live    = tok[TABLE_DEPTH].live;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= cst_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cst_pkg::S_IDLE: if (in_accept) state_d = cst_pkg::S_BUSY;
      cst_pkg::S_BUSY: if (end_live)  state_d = cst_pkg::S_IDLE;
      default:         state_d = cst_pkg::S_IDLE;
    endcase
  end

  // launch register feeds the first cell for one cycle
  always_comb begin
    launch_d          = launch_q;
    launch_d.live     = in_accept;
    launch_d.hit      = 1'b0;
    launch_d.free_ok  = 1'b0;
    if (in_accept) begin
      launch_d.action   = cst_pkg::action_e'(req_i.action);
      launch_d.ip_addr  = req_i.ip_addr;
      launch_d.port_num = req_i.port_num;
      launch_d.now_ms   = req_i.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) launch_q <= '0;
    else         launch_q <= launch_d;
  end

  assign tok[0]    = launch_q;
  assign hslot[0]  = '0;
  assign fslot[0]  = '0;
  assign pruned[0] = '0;

  // ---------------- cell row
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cst_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_IDX    (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .timeout_i    (timeout_q),
      .alloc_i      (alloc),
      .alloc_slot_i (fslot[TABLE_DEPTH]),
      .tok_i        (tok[g]),
      .hit_slot_i   (hslot[g]),
      .free_slot_i  (fslot[g]),
      .pruned_i     (pruned[g]),
      .tok_o        (tok[g+1]),
      .hit_slot_o   (hslot[g+1]),
      .free_slot_o  (fslot[g+1]),
      .pruned_o     (pruned[g+1])
    );
  end

  // ---------------- end of sweep: decide and commit
  logic [CMP_W-1:0]   lim_ext, dep_ext, lim_eff, tot_ext;
  cst_pkg::status_e   res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [CNT_W-1:0]   res_pruned;
  cst_pkg::tok_t      fin;

  always_comb begin
    fin     = tok[TABLE_DEPTH];
    lim_ext = CMP_W'(limit_q);
    dep_ext = CMP_W'(TABLE_DEPTH);
    lim_eff = (lim_ext > dep_ext) ? dep_ext : lim_ext;
    tot_ext = CMP_W'(total_q);

    total_d          = total_q;
    res_status       = cst_pkg::ST_TICK_DONE;
    res_slot         = '0;
    res_pruned       = '0;
    alloc.en         = 1'b0;
    alloc.ip_addr    = fin.ip_addr;
    alloc.port_num   = fin.port_num;
    alloc.now_ms     = fin.now_ms;

    case (fin.action)
      cst_pkg::ACT_ADD: begin
        if (fin.hit) begin
          res_status = cst_pkg::ST_REFRESHED;
          res_slot   = hslot[TABLE_DEPTH];
        end else if ((tot_ext >= lim_eff) || !fin.free_ok) begin
          res_status = cst_pkg::ST_FULL;
        end else begin
          res_status = cst_pkg::ST_ADDED;
          res_slot   = fslot[TABLE_DEPTH];
          alloc.en   = end_live;
          total_d    = total_q + CNT_W'(1);
        end
      end
      cst_pkg::ACT_REMOVE: begin
        if (fin.hit) begin
          res_status = cst_pkg::ST_REMOVED;
          if (total_q != '0) total_d = total_q - CNT_W'(1);
        end else begin
          res_status = cst_pkg::ST_NOT_FOUND;
        end
      end
      cst_pkg::ACT_FIND: begin
        if (fin.hit) begin
          res_status = cst_pkg::ST_FOUND;
          res_slot   = hslot[TABLE_DEPTH];
        end else begin
          res_status = cst_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        res_status = cst_pkg::ST_TICK_DONE;
        res_pruned = pruned[TABLE_DEPTH];
        total_d    = (total_q >= pruned[TABLE_DEPTH]) ?
                     total_q - pruned[TABLE_DEPTH] : '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       total_q <= '0;
    else if (end_live) total_q <= total_d;
  end

  // ---------------- result hold + output register
  logic [2:0] hold_status_q;
  logic [3:0] hold_slot_q;
  logic [4:0] hold_live_q;
  logic [4:0] hold_pruned_q;
  logic [2:0] out_status_q;
  logic [3:0] out_slot_q;
  logic [4:0] out_live_q;
  logic [4:0] out_pruned_q;

  logic [SLOT_W+3:0] slot_ext;
  logic [CNT_W+4:0]  live_ext;
  logic [CNT_W+4:0]  pruned_ext;

  assign slot_ext   = {4'b0, res_slot};
  assign live_ext   = {5'b0, total_d};
  assign pruned_ext = {5'b0, res_pruned};

  assign out_load = hold_valid_q && (!out_valid_q || rsp_o.ready);

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (end_live)      hold_valid_d = 1'b1;
    else if (out_load) hold_valid_d = 1'b0;
    out_valid_d = out_valid_q && !rsp_o.ready;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_live) begin
      hold_status_q <= res_status;
      hold_slot_q   <= slot_ext[3:0];
      hold_live_q   <= live_ext[4:0];
      hold_pruned_q <= pruned_ext[4:0];
    end
    if (out_load) begin
      out_status_q <= hold_status_q;
      out_slot_q   <= hold_slot_q;
      out_live_q   <= hold_live_q;
      out_pruned_q <= hold_pruned_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.slot         = out_slot_q;
  assign rsp_o.live_count   = out_live_q;
  assign rsp_o.pruned_count = out_pruned_q;

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for client_session_table_with_aging: session-table predictor in a scoreboard
// class, request/response drivers with random gaps, APB setup, watchdog.
// Depends on cst_pkg, cst_req_if / cst_rsp_if and the top level RTL.

typedef struct packed {
  cst_pkg::status_e status;
  logic [3:0]       slot;
  logic [4:0]       live_count;
  logic [4:0]       pruned_count;
} session_result_t;

class session_scoreboard;
  localparam int DEPTH = cst_pkg::TABLE_DEPTH_DEF;

  bit          occupied [DEPTH];
  logic [31:0] key_ip   [DEPTH];
  logic [15:0] key_port [DEPTH];
  logic [31:0] seen_ms  [DEPTH];
  logic [4:0]  live_total = '0;
  logic [4:0]  limit_reg = cst_pkg::LIMIT_RST;
  logic [31:0] timeout_reg = cst_pkg::TIMEOUT_RST;

  session_result_t expected_q[$];
  int errors;
  int results_seen;
  int aged_out;
  int status_seen [8];

  function int pending();
    return expected_q.size();
  endfunction

  function int find_key(logic [31:0] ip, logic [15:0] port);
    for (int k = 0; k < DEPTH; k++)
      if (occupied[k] && key_ip[k] == ip && key_port[k] == port) return k;
    return -1;
  endfunction

  function int lowest_free();
    for (int k = 0; k < DEPTH; k++)
      if (!occupied[k]) return k;
    return -1;
  endfunction

  // Work out the result of one accepted request and queue it.
  function void note_request(cst_pkg::action_e act, logic [31:0] ip, logic [15:0] port,
                             logic [31:0] now);
    session_result_t r;
    int hit;
    logic [4:0] cap;
    logic [31:0] idle;
    r.status = cst_pkg::ST_TICK_DONE;
    r.slot = '0;
    r.pruned_count = '0;
    cap = (limit_reg > DEPTH) ? 5'(DEPTH) : limit_reg;
    case (act)
      cst_pkg::ACT_ADD: begin
        hit = find_key(ip, port);
        if (hit >= 0) begin
          seen_ms[hit] = now;
          r.status = cst_pkg::ST_REFRESHED;
          r.slot = 4'(hit);
        end else begin
          hit = lowest_free();
          if (live_total >= cap || hit < 0) begin
            r.status = cst_pkg::ST_FULL;
          end else begin
            occupied[hit] = 1'b1;
            key_ip[hit] = ip;
            key_port[hit] = port;
            seen_ms[hit] = now;
            live_total++;
            r.status = cst_pkg::ST_ADDED;
            r.slot = 4'(hit);
          end
        end
      end
      cst_pkg::ACT_REMOVE: begin
        hit = find_key(ip, port);
        if (hit >= 0) begin
          occupied[hit] = 1'b0;
          live_total--;
          r.status = cst_pkg::ST_REMOVED;
        end else begin
          r.status = cst_pkg::ST_NOT_FOUND;
        end
      end
      cst_pkg::ACT_FIND: begin
        hit = find_key(ip, port);
        if (hit >= 0) begin
          r.status = cst_pkg::ST_FOUND;
          r.slot = 4'(hit);
        end else begin
          r.status = cst_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        // idle time wraps mod 2^32; strictly greater ages the entry out
        for (int k = 0; k < DEPTH; k++) begin
          idle = now - seen_ms[k];
          if (occupied[k] && idle > timeout_reg) begin
            occupied[k] = 1'b0;
            r.pruned_count++;
          end
        end
        live_total -= r.pruned_count;
        aged_out += r.pruned_count;
      end
    endcase
    r.live_count = live_total;
    expected_q = {expected_q, r};
  endfunction

  task report(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [2:0] status, logic [3:0] slot, logic [4:0] live,
                    logic [4:0] pruned);
    session_result_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected", results_seen));
      return;
    end
    want = expected_q.pop_front();
    status_seen[want.status]++;
    if (status !== want.status)
      report($sformatf("result %0d status got %0d want %0d", results_seen, status, want.status));
    if (slot !== want.slot)
      report($sformatf("result %0d slot got %0d want %0d", results_seen, slot, want.slot));
    if (live !== want.live_count)
      report($sformatf("result %0d live_count got %0d want %0d", results_seen, live,
                       want.live_count));
    if (pruned !== want.pruned_count)
      report($sformatf("result %0d pruned_count got %0d want %0d", results_seen, pruned,
                       want.pruned_count));
  endtask
endclass

module testbench;

  localparam int KEY_POOL       = 24;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_SETTLE     = 40;

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cst_req_if req ();
  cst_rsp_if rsp ();

  client_session_table_with_aging #(.TABLE_DEPTH(cst_pkg::TABLE_DEPTH_DEF)) DUT (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .req_i   (req.sink),
    .rsp_o   (rsp.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  session_scoreboard sb;
  logic [31:0] pool_ip   [KEY_POOL];
  logic [15:0] pool_port [KEY_POOL];
  logic [31:0] session_clock;
  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  int          sent_count = 0;
  int          settings_used = 0;
  int          quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_req(input cst_pkg::action_e act, input logic [31:0] ip,
                          input logic [15:0] port, input logic [31:0] now);
    int gap;
    req.valid    <= 1'b1;
    req.action   <= act;
    req.ip_addr  <= ip;
    req.port_num <= port;
    req.now_ms   <= now;
    do @(posedge clk); while (!req.ready);
    sb.note_request(act, ip, port, now);
    sent_count++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] limit, input logic [31:0] timeout);
    wait_drained();
    apb_write(cst_pkg::REG_CLIENT_LIMIT, {27'd0, limit});
    apb_write(cst_pkg::REG_TIMEOUT, timeout);
    sb.limit_reg = limit;
    sb.timeout_reg = timeout;
    settings_used++;
  endtask

  task automatic run_random(input int count, input int unsigned step_max);
    cst_pkg::action_e act;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] now;
    int          pick;
    int          k;
    int          n;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      act = (pick < 45) ? cst_pkg::ACT_ADD :
            (pick < 60) ? cst_pkg::ACT_REMOVE :
            (pick < 80) ? cst_pkg::ACT_FIND : cst_pkg::ACT_TICK;
      k = $urandom_range(0, KEY_POOL - 1);
      ip = pool_ip[k];
      port = pool_port[k];
      if ($urandom_range(0, 99) < 12) begin
        ip = $urandom;
        port = 16'($urandom_range(0, 65535));
      end
      session_clock += $urandom_range(0, step_max);
      now = ($urandom_range(0, 99) < 4) ? $urandom : session_clock;
      send_req(act, ip, port, now);
    end
  endtask

  task automatic run_directed();
    int k;
    session_clock = 32'd1000;
    send_req(cst_pkg::ACT_FIND,   pool_ip[0], pool_port[0], session_clock);  // empty table
    send_req(cst_pkg::ACT_ADD,    pool_ip[0], pool_port[0], session_clock);
    send_req(cst_pkg::ACT_ADD,    pool_ip[1], pool_port[1], session_clock);
    send_req(cst_pkg::ACT_ADD,    pool_ip[0], pool_port[0], session_clock);  // refresh
    send_req(cst_pkg::ACT_FIND,   pool_ip[1], pool_port[1], session_clock);
    // ip matches key 0 only
    send_req(cst_pkg::ACT_ADD,    pool_ip[2], pool_port[2], session_clock);
    send_req(cst_pkg::ACT_REMOVE, pool_ip[1], pool_port[1], session_clock);
    // reuses freed slot 1
    send_req(cst_pkg::ACT_ADD,    pool_ip[3], pool_port[3], session_clock);
    // idle time equal to the timeout keeps the entry, one more ages it out
    send_req(cst_pkg::ACT_TICK,   pool_ip[3], pool_port[3], session_clock + 32'd100);
    session_clock = session_clock + 32'd101;
    send_req(cst_pkg::ACT_TICK,   pool_ip[0], pool_port[0], session_clock);
    // fill all slots, then one more add hits the depth limit
    for (k = 4; k <= 20; k++)
      send_req(cst_pkg::ACT_ADD, pool_ip[k], pool_port[k], session_clock);
  endtask

  // response side: random back-pressure, plus one long hold on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_ni && rsp.valid && rsp.ready)
        sb.check_result(rsp.status, rsp.slot, rsp.live_count, rsp.pruned_count);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (calm) begin
        rsp.ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        rsp.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : main
    int k;
    sb = new;
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    req.valid    <= 1'b0;
    req.action   <= cst_pkg::ACT_ADD;
    req.ip_addr  <= '0;
    req.port_num <= '0;
    req.now_ms   <= '0;

    // extreme keys first, then random ones; from key 4 on, odd keys share the ip of the key before
    pool_ip[0] = 32'h0000_0000;  pool_port[0] = 16'h0000;
    pool_ip[1] = 32'hFFFF_FFFF;  pool_port[1] = 16'hFFFF;
    pool_ip[2] = 32'h0000_0000;  pool_port[2] = 16'hFFFF;
    pool_ip[3] = 32'hFFFF_FFFF;  pool_port[3] = 16'h0000;
    for (k = 4; k < KEY_POOL; k++) begin
      pool_ip[k] = (k % 2) ? pool_ip[k-1] : $urandom;
      pool_port[k] = 16'($urandom_range(0, 65535));
    end

    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    set_config(5'd31, 32'd100);          // limit above depth saturates
    run_directed();

    set_config(5'd16, 32'd10000);
    run_random(30, 300);
    hold_request = 1'b1;                 // receiver holds off, sender keeps offering
    run_random(30, 300);
    wait_drained();                      // sender pauses until all results are back
    run_random(40, 300);

    set_config(5'd0, 32'd0);             // no new entry can be added, only refreshes
    run_random(50, 2);

    set_config(5'd5, 32'd300);
    session_clock = 32'hFFFF_F000;       // time wraps during this phase
    run_random(120, 120);

    set_config(5'd31, 32'hFFFF_FFFF);    // nothing ever ages out
    calm = 1'b1;
    run_random(40, 5000);
    calm = 1'b0;
    run_random(60, 50000);

    set_config(5'd1, $urandom_range(20, 200));
    run_random(60, 60);

    set_config(5'($urandom_range(0, 31)), $urandom_range(50, 2000));
    run_random(80, 200);

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);

    $display("Covered %0d requests over %0d register settings, incl. limit 0/over depth,",
             sent_count, settings_used);
    $display("  timeouts 0/all ones, time wrap; %0d added %0d refreshed %0d full %0d aged out.",
             sb.status_seen[cst_pkg::ST_ADDED], sb.status_seen[cst_pkg::ST_REFRESHED],
             sb.status_seen[cst_pkg::ST_FULL], sb.aged_out);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
